// ===== rtl/core/bdq_pkg.sv =====
// Package for the bounded deque: word and field widths, request and status
// codes, and the command that the top level broadcasts to every cell.
// No dependencies.
package bdq_pkg;

  // Built depth of the cell row unless the top level is given another.
  localparam int DEPTH_DEFAULT = 16;

  // Field widths.
  localparam int WORD_W = 32;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;
  localparam int CAP_W  = 5;

  // Capacity register after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Request codes.
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_REAR  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 2'd2;
  localparam logic [FUNC_W-1:0] FN_POP_REAR   = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // Word returned by a pop from an empty deque.
  localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

  // Command seen by every cell in the row; at most one bit is set.
  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
  } bdq_cell_cmd_t;

endpackage

// ===== rtl/core/bounded_deque.sv =====
// Top level of the bounded deque: request decode, count and capacity logic,
// the row of cells and the result register.
// Depends on bdq_pkg and bdq_cell.
//
// A bounded double-ended queue of signed 32-bit words built as a row of
// DEPTH cells kept packed toward the front: cell 0 holds the front word and
// the last occupied cell holds the rear word. The row shifts or fills and
// the result goes into an output register at the same edge, so a new word
// is taken every cycle as long as the result side takes its words (in_ready
// is low only while a result waits). The path that sets the clock is the
// rear read, an OR tree over the taps of all DEPTH cells. Pushes are
// refused with the full status once the count reaches min(capacity, DEPTH);
// pops from an empty deque return -1 with the empty status. Capacity is to
// be written through cfg_wen/cfg_wdata only while the block is idle, which
// the block does not enforce. No clearing pass is needed after reset.
module bounded_deque #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration.
  input  logic                                cfg_wen,
  input  logic [bdq_pkg::CAP_W-1:0]           cfg_wdata,
  // Request channel.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bdq_pkg::FUNC_W-1:0]          func,
  input  logic signed [bdq_pkg::WORD_W-1:0]   value,
  // Result channel.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bdq_pkg::WORD_W-1:0]   popped_value,
  output logic [bdq_pkg::STAT_W-1:0]          status,
  output logic [CNT_W-1:0]                    occupancy
);
  import bdq_pkg::*;

  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CAP_W-1:0]         capacity;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic [CMP_W-1:0]         cap_ext;
  logic [CMP_W-1:0]         limit;
  logic                     accept;
  logic                     is_push;
  logic                     full;
  logic                     empty;
  bdq_cell_cmd_t            cmd;
  logic signed [WORD_W-1:0] rear_word;
  logic signed [WORD_W-1:0] result_word;
  logic [STAT_W-1:0]        result_status;

  logic                     occ_vec  [DEPTH];
  logic signed [WORD_W-1:0] data_vec [DEPTH];
  logic signed [WORD_W-1:0] tap_vec  [DEPTH];

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wen) begin
      capacity <= cfg_wdata;
    end
  end

  // The limit in force is the smaller of capacity and the built depth.
  assign cap_ext = CMP_W'(capacity);
  assign limit   = (cap_ext < CMP_W'(DEPTH)) ? cap_ext : CMP_W'(DEPTH);
  assign full    = (CMP_W'(count) >= limit);
  assign empty   = (count == '0);

  // A new word is taken whenever the result register is free or emptying.
  assign in_ready = ~out_valid | out_ready;
  assign accept   = in_valid & in_ready;
  assign is_push  = (func == FN_PUSH_FRONT) || (func == FN_PUSH_REAR);

  // Decode the request into the row command; refused requests do nothing.
  always_comb begin
    cmd = '0;
    if (accept) begin
      unique case (func)
        FN_PUSH_FRONT: cmd.push_front = ~full;
        FN_PUSH_REAR:  cmd.push_rear  = ~full;
        FN_POP_FRONT:  cmd.pop_front  = ~empty;
        FN_POP_REAR:   cmd.pop_rear   = ~empty;
        default:       cmd = '0;
      endcase
    end
  end

  // Entry count.
  always_comb begin
    count_next = count;
    if (cmd.push_front || cmd.push_rear) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.pop_front || cmd.pop_rear) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // The row of cells; cell 0 is the front.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     occ_l;
    logic                     occ_r;
    logic signed [WORD_W-1:0] data_l;
    logic signed [WORD_W-1:0] data_r;

    if (i == 0) begin : g_front
      assign occ_l  = 1'b1;
      assign data_l = value;
    end else begin : g_inner_l
      assign occ_l  = occ_vec[i-1];
      assign data_l = data_vec[i-1];
    end

    if (i == DEPTH - 1) begin : g_rear
      assign occ_r  = 1'b0;
      assign data_r = '0;
    end else begin : g_inner_r
      assign occ_r  = occ_vec[i+1];
      assign data_r = data_vec[i+1];
    end

    bdq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .push_word  (value),
      .occ_left   (occ_l),
      .data_left  (data_l),
      .occ_right  (occ_r),
      .data_right (data_r),
      .occ        (occ_vec[i]),
      .data       (data_vec[i]),
      .rear_tap   (tap_vec[i])
    );
  end

  // Only one cell drives a nonzero tap, so an OR gathers the rear word.
  always_comb begin
    rear_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_word = rear_word | tap_vec[i];
    end
  end

  // Result word and status for the request being taken.
  always_comb begin
    result_word   = '0;
    result_status = ST_DONE;
    if (is_push) begin
      if (full) begin
        result_status = ST_FULL;
      end
    end else if (empty) begin
      result_status = ST_EMPTY;
      result_word   = EMPTY_WORD;
    end else if (func == FN_POP_FRONT) begin
      result_word = data_vec[0];
    end else begin
      result_word = rear_word;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_value <= result_word;
      status       <= result_status;
      occupancy    <= count_next;
    end
  end

endmodule

// ===== rtl/core/bdq_cell.sv =====
// One cell of the deque row: holds one word and an occupied flag and trades
// words with its two neighbors when the row shifts.
// Depends on bdq_pkg.
module bdq_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  bdq_pkg::bdq_cell_cmd_t             cmd,
  input  logic signed [bdq_pkg::WORD_W-1:0]  push_word,
  input  logic                               occ_left,
  input  logic signed [bdq_pkg::WORD_W-1:0]  data_left,
  input  logic                               occ_right,
  input  logic signed [bdq_pkg::WORD_W-1:0]  data_right,
  output logic                               occ,
  output logic signed [bdq_pkg::WORD_W-1:0]  data,
  output logic signed [bdq_pkg::WORD_W-1:0]  rear_tap
);
  import bdq_pkg::*;

  logic                     occ_next;
  logic signed [WORD_W-1:0] data_next;
  logic                     is_rear;
  logic                     is_first_free;

  // The rear cell is the last occupied one; the first free cell takes a
  // word pushed at the rear.
  assign is_rear       = occ & ~occ_right;
  assign is_first_free = occ_left & ~occ;

  // Occupied flags form a thermometer that grows or shrinks by one.
  always_comb begin
    occ_next = occ;
    if (cmd.push_front || cmd.push_rear) begin
      occ_next = occ_left;
    end else if (cmd.pop_front || cmd.pop_rear) begin
      occ_next = occ_right;
    end
  end

  // Words move toward the rear on a front push and toward the front on a
  // front pop; a rear push lands in the first free cell.
  always_comb begin
    data_next = data;
    if (cmd.push_front) begin
      data_next = data_left;
    end else if (cmd.push_rear && is_first_free) begin
      data_next = push_word;
    end else if (cmd.pop_front) begin
      data_next = data_right;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // Only the rear cell drives its word onto the rear read tree.
  assign rear_tap = is_rear ? data : '0;

endmodule

// ===== rtl/core/bdq_check.sv =====
// Port-level checker for the bounded deque, bound to the top level.
// Depends on bdq_pkg and bounded_deque.
module bdq_check #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [bdq_pkg::WORD_W-1:0]   popped_value,
  input logic [bdq_pkg::STAT_W-1:0]          status,
  input logic [CNT_W-1:0]                    occupancy
);
  import bdq_pkg::*;

  // An empty pop returns -1 and leaves the deque empty.
  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> popped_value == EMPTY_WORD && occupancy == '0)
    else $error("empty pop must return -1 with zero occupancy");

  // A refused push returns zero; with capacity zero the deque may still be empty.
  a_full_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> popped_value == '0)
    else $error("full refusal must return zero");

  // Occupancy never exceeds the built depth.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> occupancy <= CNT_W'(DEPTH))
    else $error("occupancy beyond built depth");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(popped_value) && $stable(status))
    else $error("result word changed while stalled");

  // Every accepted request word has its result on offer in the next cycle.
  a_in_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request produced no result");

endmodule

bind bounded_deque bdq_check #(.DEPTH(DEPTH), .CNT_W(CNT_W)) u_bdq_check (.*);
